// ===== rtl/lrl_pkg.sv =====
// LRU replacement list: shared operation codes and the control bundle
// that the list control drives into every slot cell. No dependencies.
package lrl_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_VICTIM = 2'd1,
        CMD_ERASE  = 2'd2
    } lrl_cmd_t;

    localparam int unsigned KEY_W   = 16;
    localparam int unsigned COUNT_W = 5;

    typedef struct packed {
        logic             shift_en;
        logic             shift_all;
        logic             load_en;
        logic [KEY_W-1:0] key;
    } lrl_ctrl_t;

endpackage

// ===== rtl/lrl_cell.sv =====
// LRU replacement list: one slot cell. Holds one key, compares it with the
// lookup key, and shifts or loads under the shared control. Uses lrl_pkg.
module lrl_cell
    import lrl_pkg::*;
#(
    parameter int unsigned IDX   = 0,
    parameter int unsigned CNT_W = 5,
    parameter int unsigned IDX_W = 4
) (
    input  logic             aclk,
    input  lrl_ctrl_t        ctrl,
    input  logic [CNT_W-1:0] count,
    input  logic [IDX_W-1:0] load_idx,
    input  logic             match_in,
    input  logic [KEY_W-1:0] nbr_key,
    output logic             match_out,
    output logic [KEY_W-1:0] key_out
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             occupied;

    assign occupied  = CNT_W'(IDX) < count;
    assign match_out = match_in | (occupied && (key_reg == ctrl.key));
    assign key_out   = key_reg;

    always_comb begin
        priority if (ctrl.load_en && (load_idx == IDX_W'(IDX))) begin
            key_next = ctrl.key;
        end else if (ctrl.shift_en && (ctrl.shift_all || match_out)) begin
            key_next = nbr_key;
        end else begin
            key_next = key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

// ===== rtl/lru_replacement_list.sv =====
// LRU replacement list top level: list control, row of slot cells and the
// result register. Uses lrl_pkg and lrl_cell.
//
// Usage: each transfer on the s_ channel carries one operation (s_cmd) and a
// key (s_key). Insert moves a present key to most recent or appends a new one;
// a new key offered to a full list is dropped with m_overflow set. Victim pops
// the least recent key into m_victim_key. Erase removes a key, m_ok telling
// whether it was present. Every operation gives exactly one m_ transfer with
// the number of keys held afterwards in m_count.
// The result is registered, valid in the cycle after the transfer. Throughput:
// one operation per cycle when not stalled; all cells compare in parallel, and a
// match ripples along the cell chain to select the cells shifting to the old end.
// Stall: the result register holds while m_ready is low, and s_ready follows
// it, so a new operation is taken in the same cycle the pending result leaves.
// Reset: the count clears and the list is empty at once; no clearing pass.
module lru_replacement_list
    import lrl_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic [KEY_W-1:0]   s_key,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_ok,
    output logic [KEY_W-1:0]   m_victim_key,
    output logic [COUNT_W-1:0] m_count,
    output logic               m_overflow
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned IDX_W = $clog2(CAPACITY);

    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               m_valid_reg;
    logic               m_ok_reg;
    logic [KEY_W-1:0]   m_victim_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic               m_overflow_reg;

    logic               fire;
    logic               is_ins, is_vic, is_era;
    logic               hit, full, empty;
    logic               ins_ok, ins_new, vic_ok, era_ok, ovf;
    logic [31:0]        cnt_wide;
    logic [IDX_W-1:0]   load_idx;
    lrl_ctrl_t          ctrl;

    logic [CAPACITY:0]  match_chain;
    logic [KEY_W-1:0]   cell_key [CAPACITY+1];

    assign s_ready = !m_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;

    assign is_ins = s_cmd == CMD_INSERT;
    assign is_vic = s_cmd == CMD_VICTIM;
    assign is_era = s_cmd == CMD_ERASE;

    assign hit   = match_chain[CAPACITY];
    assign full  = cnt_reg == CNT_W'(CAPACITY);
    assign empty = cnt_reg == '0;

    assign ins_new = is_ins && !hit && !full;
    assign ins_ok  = is_ins && (hit || !full);
    assign ovf     = is_ins && !hit && full;
    assign vic_ok  = is_vic && !empty;
    assign era_ok  = is_era && hit;

    always_comb begin
        priority if (ins_new) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (vic_ok || era_ok) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end else begin
            cnt_next = cnt_reg;
        end
    end

    assign cnt_wide = 32'(cnt_next);
    assign load_idx = IDX_W'(cnt_next - CNT_W'(1));

    always_comb begin
        ctrl.shift_en  = fire && ((is_ins && hit) || era_ok || vic_ok);
        ctrl.shift_all = is_vic;
        ctrl.load_en   = fire && ins_ok;
        ctrl.key       = s_key;
    end

    assign match_chain[0]     = 1'b0;
    assign cell_key[CAPACITY] = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        lrl_cell #(
            .IDX   (i),
            .CNT_W (CNT_W),
            .IDX_W (IDX_W)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .count     (cnt_reg),
            .load_idx  (load_idx),
            .match_in  (match_chain[i]),
            .nbr_key   (cell_key[i+1]),
            .match_out (match_chain[i+1]),
            .key_out   (cell_key[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                cnt_reg <= cnt_next;
            end
            if (s_ready) begin
                m_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_ok_reg       <= ins_ok || vic_ok || era_ok;
            m_victim_reg   <= vic_ok ? cell_key[0] : '0;
            m_count_reg    <= cnt_wide[COUNT_W-1:0];
            m_overflow_reg <= ovf;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ok         = m_ok_reg;
    assign m_victim_key = m_victim_reg;
    assign m_count      = m_count_reg;
    assign m_overflow   = m_overflow_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("key count exceeds capacity");

    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (cnt_reg == $past(cnt_reg) || cnt_reg == $past(cnt_reg) + CNT_W'(1)
                  || cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("key count moved by more than one");

    a_ovf_not_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_overflow) |-> !m_ok)
        else $error("dropped insert reported as done");

    a_hold_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> cnt_reg == $past(cnt_reg))
        else $error("key count changed without a transfer");

endmodule
